// ===== src/fort_pkg.sv =====
// Shared types, codes and defaults for the frame offset remap table.
package fort_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int FRAME_WIDTH_DEFAULT = 32;
   localparam int ACTION_W            = 2;
   localparam int STATUS_W            = 3;

   localparam logic [ACTION_W-1:0] ACT_TRANSLATE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD       = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_INITIAL   = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_NEGATIVE  = 3'd1,
      STAT_ORDER     = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_NOT_EMPTY = 3'd4,
      STAT_OVERFLOW  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load_item;
      logic exec;
      logic scan;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic scan_needed;
      logic scan_done;
   } stat_type;

endpackage

// ===== src/fort_req_if.sv =====
// Request channel: action, frame number and adjustment with valid/ready.
interface fort_req_if #(
   parameter int FRAME_WIDTH = fort_pkg::FRAME_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic [fort_pkg::ACTION_W-1:0] action;
   logic [FRAME_WIDTH-1:0]        frame_number;
   logic [FRAME_WIDTH-1:0]        adjustment;

   modport source (output valid, action, frame_number, adjustment, input ready);
   modport sink   (input valid, action, frame_number, adjustment, output ready);
endinterface

// ===== src/fort_rsp_if.sv =====
// Response channel: adjusted frame and status with valid/ready.
interface fort_rsp_if #(
   parameter int FRAME_WIDTH = fort_pkg::FRAME_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic [FRAME_WIDTH-1:0]        adjusted_frame;
   logic [fort_pkg::STATUS_W-1:0] status;

   modport source (output valid, adjusted_frame, status, input ready);
   modport sink   (input valid, adjusted_frame, status, output ready);
endinterface

// ===== src/fort_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fort_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/fort_ctrl.sv =====
// Controller state machine: sequences accept, execute, table scan and response.
module fort_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fort_pkg::cmd_type cmd,
   input  fort_pkg::stat_type stat
);
   fort_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fort_pkg::S_IDLE: begin
            if (req_valid) state_in = fort_pkg::S_EXEC;
         end
         fort_pkg::S_EXEC: begin
            state_in = stat.scan_needed ? fort_pkg::S_SCAN : fort_pkg::S_FINISH;
         end
         fort_pkg::S_SCAN: begin
            if (stat.scan_done) state_in = fort_pkg::S_FINISH;
         end
         fort_pkg::S_FINISH: begin
            if (out_free) state_in = fort_pkg::S_IDLE;
         end
         default: begin
            state_in = fort_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         fort_pkg::S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         fort_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
         end
         fort_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
         end
         fort_pkg::S_FINISH: begin
            cmd.load_out = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // hold the response until taken, refill from the finish state
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fort_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== src/fort_datapath.sv =====
// Datapath: request registers, table RAM, append checks, backward scan, response register.
module fort_datapath #(
   parameter int DEPTH       = fort_pkg::DEPTH_DEFAULT,
   parameter int FRAME_WIDTH = fort_pkg::FRAME_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fort_pkg::cmd_type             cmd,
   output fort_pkg::stat_type            stat,
   input  logic [fort_pkg::ACTION_W-1:0] req_action,
   input  logic [FRAME_WIDTH-1:0]        req_frame,
   input  logic [FRAME_WIDTH-1:0]        req_adjust,
   output logic [FRAME_WIDTH-1:0]        rsp_frame,
   output logic [fort_pkg::STATUS_W-1:0] rsp_status
);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = 2 * FRAME_WIDTH;

   logic [fort_pkg::ACTION_W-1:0] action_ff, action_in;
   logic [FRAME_WIDTH-1:0]        frame_ff, frame_in;
   logic [FRAME_WIDTH-1:0]        adjust_ff, adjust_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [FRAME_WIDTH-1:0]        last_start_ff, last_start_in;
   logic [FRAME_WIDTH-1:0]        last_offset_ff, last_offset_in;
   logic [IDX_W-1:0]              scan_idx_ff, scan_idx_in;
   logic [FRAME_WIDTH-1:0]        result_ff, result_in;
   fort_pkg::status_type          status_ff, status_in;
   logic [FRAME_WIDTH-1:0]        out_frame_ff, out_frame_in;
   fort_pkg::status_type          out_status_ff, out_status_in;

   logic                   table_empty;
   logic                   table_full;
   logic [CNT_W-1:0]       count_m1;
   logic [FRAME_WIDTH-1:0] base_offset;
   logic [FRAME_WIDTH-1:0] add_adjust;
   logic [FRAME_WIDTH:0]   offset_sum;
   fort_pkg::status_type   add_status;
   logic                   commit;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [ENTRY_W-1:0]     rd_data;
   logic [FRAME_WIDTH-1:0] rd_start;
   logic [FRAME_WIDTH-1:0] rd_offset;
   logic                   match;
   logic                   idx_zero;

   fort_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // append checks, in priority order
   always_comb begin
      table_empty = (count_ff == '0);
      table_full  = (count_ff == CNT_W'(DEPTH));
      count_m1    = count_ff - CNT_W'(1);
      base_offset = table_empty ? '0 : last_offset_ff;
      add_adjust  = (action_ff == fort_pkg::ACT_INITIAL) ? frame_ff : adjust_ff;
      offset_sum  = {1'b0, base_offset} + {1'b0, add_adjust};
      if (frame_ff < add_adjust) begin
         add_status = fort_pkg::STAT_NEGATIVE;
      end else if (!table_empty && (last_start_ff >= frame_ff)) begin
         add_status = fort_pkg::STAT_ORDER;
      end else if (table_full) begin
         add_status = fort_pkg::STAT_FULL;
      end else if (offset_sum[FRAME_WIDTH]) begin
         add_status = fort_pkg::STAT_OVERFLOW;
      end else begin
         add_status = fort_pkg::STAT_OK;
      end
   end

   always_comb begin
      rd_start         = rd_data[ENTRY_W-1:FRAME_WIDTH];
      rd_offset        = rd_data[FRAME_WIDTH-1:0];
      match            = (rd_start <= frame_ff);
      idx_zero         = (scan_idx_ff == '0);
      stat.scan_needed = (action_ff == fort_pkg::ACT_TRANSLATE) && !table_empty;
      stat.scan_done   = match || idx_zero;
   end

   always_comb begin
      action_in      = action_ff;
      frame_in       = frame_ff;
      adjust_in      = adjust_ff;
      count_in       = count_ff;
      last_start_in  = last_start_ff;
      last_offset_in = last_offset_ff;
      scan_idx_in    = scan_idx_ff;
      result_in      = result_ff;
      status_in      = status_ff;
      out_frame_in   = out_frame_ff;
      out_status_in  = out_status_ff;
      commit         = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = scan_idx_ff - IDX_W'(1);

      if (cmd.load_item) begin
         action_in = req_action;
         frame_in  = req_frame;
         adjust_in = req_adjust;
      end

      if (cmd.exec) begin
         result_in = '0;
         status_in = fort_pkg::STAT_OK;
         case (action_ff)
            fort_pkg::ACT_TRANSLATE: begin
               // empty table passes the frame through; otherwise start at the newest entry
               result_in   = frame_ff;
               scan_idx_in = count_m1[IDX_W-1:0];
               rd_addr     = count_m1[IDX_W-1:0];
               rd_en       = !table_empty;
            end
            fort_pkg::ACT_ADD: begin
               status_in = add_status;
               commit    = (add_status == fort_pkg::STAT_OK);
            end
            fort_pkg::ACT_INITIAL: begin
               if (!table_empty) begin
                  status_in = fort_pkg::STAT_NOT_EMPTY;
               end else begin
                  status_in = add_status;
                  commit    = (add_status == fort_pkg::STAT_OK);
               end
            end
            default: begin
               result_in = '0;
            end
         endcase
      end

      if (cmd.scan) begin
         if (match) begin
            result_in = frame_ff - rd_offset;
         end else if (idx_zero) begin
            result_in = frame_ff;
         end else begin
            // step back one entry
            scan_idx_in = scan_idx_ff - IDX_W'(1);
            rd_en       = 1'b1;
         end
      end

      if (commit) begin
         count_in       = count_ff + CNT_W'(1);
         last_start_in  = frame_ff;
         last_offset_in = offset_sum[FRAME_WIDTH-1:0];
      end

      if (cmd.load_out) begin
         out_frame_in  = result_ff;
         out_status_in = status_ff;
      end
   end

   always_comb begin
      wr_en   = commit;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = {frame_ff, offset_sum[FRAME_WIDTH-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      frame_ff       <= frame_in;
      adjust_ff      <= adjust_in;
      last_start_ff  <= last_start_in;
      last_offset_ff <= last_offset_in;
      scan_idx_ff    <= scan_idx_in;
      result_ff      <= result_in;
      status_ff      <= status_in;
      out_frame_ff   <= out_frame_in;
      out_status_ff  <= out_status_in;
   end

   assign rsp_frame  = out_frame_ff;
   assign rsp_status = out_status_ff;
endmodule

// ===== src/frame_offset_remap_table.sv =====
// Top level of the frame offset remap table: controller, datapath and channel hookup.
//
// Keeps an append-only table of up to DEPTH entries (start frame, cumulative
// offset) in a single-port-read RAM and answers one request at a time. Add,
// initial and unused-action requests go from acceptance through the execute
// and finish states back to idle; a translate on a non-empty table also
// passes through the scan state, where the backward scan examines 1 to the
// number of stored entries, one RAM read per cycle. A finished response waits in
// its output register, so a new request is accepted while it is unclaimed.
// The table needs no clearing pass after reset.
module frame_offset_remap_table #(
   parameter int DEPTH       = fort_pkg::DEPTH_DEFAULT,
   parameter int FRAME_WIDTH = fort_pkg::FRAME_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   fort_req_if.sink  req_ch,
   fort_rsp_if.source rsp_ch
);
   fort_pkg::cmd_type  cmd;
   fort_pkg::stat_type stat;

   fort_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   fort_datapath #(
      .DEPTH       (DEPTH),
      .FRAME_WIDTH (FRAME_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_action (req_ch.action),
      .req_frame  (req_ch.frame_number),
      .req_adjust (req_ch.adjustment),
      .rsp_frame  (rsp_ch.adjusted_frame),
      .rsp_status (rsp_ch.status)
   );
endmodule

// ===== src/fort_checker.sv =====
// Port-level checks on the frame offset remap table, bound to the top level.
module fort_checker #(
   parameter int FRAME_WIDTH = fort_pkg::FRAME_WIDTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [FRAME_WIDTH-1:0]        rsp_adjusted_frame,
   input logic [fort_pkg::STATUS_W-1:0] rsp_status
);
   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_adjusted_frame)
         && $stable(rsp_status))
      else $error("response changed while stalled");

   // one request at a time: no request is taken right after another
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= fort_pkg::STAT_OVERFLOW)
      else $error("status code out of range");

   // refused updates carry no frame
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != fort_pkg::STAT_OK) |-> rsp_adjusted_frame == '0)
      else $error("refused request returned a nonzero frame");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind frame_offset_remap_table fort_checker #(
   .FRAME_WIDTH (FRAME_WIDTH)
) u_fort_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_adjusted_frame (rsp_ch.adjusted_frame),
   .rsp_status         (rsp_ch.status)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for frame_offset_remap_table: directed and random requests.
module tb;

   localparam int DEPTH        = fort_pkg::DEPTH_DEFAULT;
   localparam int FW           = fort_pkg::FRAME_WIDTH_DEFAULT;
   localparam int SETTLE_CYCLES = DEPTH + 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic [fort_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef logic [FW-1:0] frame_type;

   typedef struct packed {
      frame_type            adjusted_frame;
      fort_pkg::status_type status;
   } remap_result_type;

   logic clock;
   logic reset;

   fort_req_if #(.FRAME_WIDTH(FW)) req_ch ();
   fort_rsp_if #(.FRAME_WIDTH(FW)) rsp_ch ();

   frame_offset_remap_table #(
      .DEPTH      (DEPTH),
      .FRAME_WIDTH(FW)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Local copy of the offset table
   frame_type        table_start  [DEPTH];
   frame_type        table_offset [DEPTH];
   int unsigned      table_count = 0;
   remap_result_type remap_results_due [$];
   remap_result_type oldest_remap;
   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;
   bit               steady = 1'b0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("frame_offset_remap_table regression: fail");
         $finish;
      end
   end

   function automatic fort_pkg::status_type append_entry(frame_type start, frame_type adj);
      frame_type base;
      base = '0;
      if (start < adj) return fort_pkg::STAT_NEGATIVE;
      if (table_count > 0 && table_start[table_count-1] >= start)
         return fort_pkg::STAT_ORDER;
      if (table_count >= DEPTH) return fort_pkg::STAT_FULL;
      if (table_count > 0) base = table_offset[table_count-1];
      // all-ones minus base is the headroom left for the adjustment
      if (adj > ~base) return fort_pkg::STAT_OVERFLOW;
      table_start[table_count]  = start;
      table_offset[table_count] = base + adj;
      table_count++;
      return fort_pkg::STAT_OK;
   endfunction

   function automatic frame_type translate_frame(frame_type frame);
      for (int i = int'(table_count) - 1; i >= 0; i--)
         if (table_start[i] <= frame) return frame - table_offset[i];
      return frame;
   endfunction

   function automatic remap_result_type predict_remap(
      logic [fort_pkg::ACTION_W-1:0] action, frame_type frame, frame_type adj);
      remap_result_type r;
      r.adjusted_frame = '0;
      r.status         = fort_pkg::STAT_OK;
      case (action)
         fort_pkg::ACT_TRANSLATE: r.adjusted_frame = translate_frame(frame);
         fort_pkg::ACT_ADD:       r.status = append_entry(frame, adj);
         fort_pkg::ACT_INITIAL:   r.status = (table_count != 0) ? fort_pkg::STAT_NOT_EMPTY
                                                                : append_entry(frame, frame);
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic send_request(logic [fort_pkg::ACTION_W-1:0] action, frame_type frame,
                               frame_type adj);
      while (!steady && $urandom_range(99) < 33) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.action       <= action;
      req_ch.frame_number <= frame;
      req_ch.adjustment   <= adj;
      do @(posedge clock); while (!req_ch.ready);
      remap_results_due.push_back(predict_remap(action, frame, adj));
   endtask

   // Drop valid and hold off until every response is back
   task automatic hold_until_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (remap_results_due.size() != 0) @(posedge clock);
   endtask

   always @(negedge clock)
      rsp_ch.ready <= steady || ($urandom_range(99) >= 33);

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (remap_results_due.size() == 0) begin
            report_mismatch($sformatf("response with none due: frame %h status %0d",
                                      rsp_ch.adjusted_frame, rsp_ch.status));
         end else begin
            oldest_remap = remap_results_due.pop_front();
            if (rsp_ch.adjusted_frame !== oldest_remap.adjusted_frame)
               report_mismatch($sformatf("adjusted_frame got %h want %h",
                                         rsp_ch.adjusted_frame,
                                         oldest_remap.adjusted_frame));
            if (rsp_ch.status !== oldest_remap.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_ch.status, oldest_remap.status));
         end
      end
   end

   task automatic test_empty_table();
      send_request(fort_pkg::ACT_TRANSLATE, '0, '0);
      send_request(fort_pkg::ACT_TRANSLATE, '1, '1);
      send_request(ACT_UNUSED, $urandom(), $urandom());
      send_request(fort_pkg::ACT_ADD, 32'd5, 32'd6);
      send_request(fort_pkg::ACT_ADD, '0, '1);
   endtask

   task automatic test_initial_entry();
      send_request(fort_pkg::ACT_INITIAL, 32'd1000, $urandom());
      send_request(fort_pkg::ACT_INITIAL, 32'd50, '0);
      send_request(fort_pkg::ACT_TRANSLATE, 32'd999, '0);
      send_request(fort_pkg::ACT_TRANSLATE, 32'd1000, '0);
      send_request(fort_pkg::ACT_TRANSLATE, 32'd1001, '0);
   endtask

   task automatic test_add_refusals();
      send_request(fort_pkg::ACT_ADD, 32'd1000, '0);
      send_request(fort_pkg::ACT_ADD, 32'd500, '0);
      send_request(fort_pkg::ACT_ADD, 32'd3, 32'd4);
      send_request(fort_pkg::ACT_ADD, '1, '1);
      send_request(fort_pkg::ACT_ADD, 32'd2000, 32'd1500);
      // offset now exceeds the start frame, so this wraps
      send_request(fort_pkg::ACT_TRANSLATE, 32'd2000, '0);
      send_request(fort_pkg::ACT_TRANSLATE, '1, '0);
      send_request(fort_pkg::ACT_TRANSLATE, 32'd1999, '1);
      send_request(ACT_UNUSED, '1, '1);
      send_request(fort_pkg::ACT_ADD, 32'd3000, '0);
   endtask

   task automatic test_random_traffic(int unsigned n_items);
      int unsigned                   pick;
      int unsigned                   idx;
      frame_type                     frame;
      frame_type                     adj;
      frame_type                     newest;
      logic [fort_pkg::ACTION_W-1:0] action;
      repeat (n_items) begin
         pick   = $urandom_range(99);
         newest = (table_count > 0) ? table_start[table_count-1] : '0;
         frame  = $urandom();
         adj    = $urandom();
         if (pick < 55) begin
            action = fort_pkg::ACT_TRANSLATE;
            if (table_count > 0 && $urandom_range(3) != 0) begin
               idx = $urandom_range(table_count - 1);
               case ($urandom_range(2))
                  0: frame = table_start[idx] - 1;
                  1: frame = table_start[idx];
                  default: frame = table_start[idx] + $urandom_range(1 << 24);
               endcase
            end
         end else if (pick < 85) begin
            action = fort_pkg::ACT_ADD;
            // mostly in-order appends so the table fills and then reports full
            if ($urandom_range(3) != 0) begin
               frame = newest + $urandom_range(1 << 24, 1);
               adj   = $urandom_range(2000);
            end
         end else if (pick < 92) begin
            action = fort_pkg::ACT_INITIAL;
         end else begin
            action = ACT_UNUSED;
         end
         send_request(action, frame, adj);
      end
   endtask

   task automatic test_back_to_back(int unsigned n_items);
      steady = 1'b1;
      test_random_traffic(n_items);
      hold_until_drained();
      steady = 1'b0;
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.action       = fort_pkg::ACT_TRANSLATE;
      req_ch.frame_number = '0;
      req_ch.adjustment   = '0;
      rsp_ch.ready        = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_initial_entry();
      test_add_refusals();
      hold_until_drained();
      test_random_traffic(250);
      hold_until_drained();
      test_back_to_back(100);
      test_random_traffic(100);

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("frame_offset_remap_table regression: pass");
      else
         $display("frame_offset_remap_table regression: fail");
      $finish;
   end

endmodule
